FILE: rtl/modular_exponentiation_core_assert.svh
// ----------------------------------------------------------------------------
// modular_exponentiation_core_assert
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
// Both report through $error and are disabled while reset is low.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Same-cycle implication (or any property) sampled on the clock.
`define MXP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mxp assertion failed");

// Antecedent in one cycle, consequent in the next.
`define MXP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mxp assertion failed");

`endif

FILE: rtl/mxp_pkg.sv
// ----------------------------------------------------------------------------
// mxp_pkg
// Types and constants of the modular exponentiation core.
// ----------------------------------------------------------------------------
package mxp_pkg;

  localparam int unsigned WordW = 32;  // datapath / result width
  localparam int unsigned ModW  = 31;  // modulus, base width
  localparam int unsigned ExpW  = 31;  // exponent width
  localparam int unsigned CntW  = 5;   // bit counter over one word
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgUseModulus = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgModulus    = 1'b1;

  localparam logic [ModW-1:0] ModulusReset = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StReduce = 4'b0010,
    StMult   = 4'b0100,
    StFinish = 4'b1000
  } mxp_state_e;

  // control of one bit-serial multiply cell
  typedef struct packed {
    logic clr;       // clear the partial product
    logic step;      // take one multiplier bit
    logic scan_bit;  // current multiplier bit, MSB first
    logic mod_en;    // reduce by modulus, else wrap
  } mxp_cell_ctrl_t;

endpackage

FILE: rtl/mxp_if.sv
// ----------------------------------------------------------------------------
// mxp_in_if / mxp_out_if
// Valid/ready channels carrying requests into and results out of the core.
// ----------------------------------------------------------------------------
interface mxp_in_if;
  import mxp_pkg::*;
  logic            valid;
  logic            ready;
  logic [ModW-1:0] base_value;
  logic [ExpW-1:0] exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mxp_out_if;
  import mxp_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

FILE: rtl/mxp_mul_cell.sv
// ----------------------------------------------------------------------------
// mxp_mul_cell
// Bit-serial interleaved multiplier: r = 2r + bit*addend, reduced by the
// modulus (at most two subtractions) or wrapped to PlainW bits.
// ----------------------------------------------------------------------------
module mxp_mul_cell #(
  parameter int unsigned PlainW = 32
) (
  input  logic                          clk_i,
  input  mxp_pkg::mxp_cell_ctrl_t       ctrl_i,
  input  logic [mxp_pkg::WordW-1:0]     addend_i,
  input  logic [mxp_pkg::ModW-1:0]      modulus_i,
  output logic [mxp_pkg::WordW-1:0]     prod_o
);
  import mxp_pkg::*;

  localparam int unsigned TW = WordW + 2;

  logic [WordW-1:0] r_q, r_d;
  logic [TW-1:0]    t, t1, t2;

  always_comb begin
    t  = {1'b0, r_q, 1'b0} + (ctrl_i.scan_bit ? {2'b00, addend_i} : '0);
    t1 = t - {{(TW-ModW){1'b0}}, modulus_i};
    t2 = t - {{(TW-ModW-1){1'b0}}, modulus_i, 1'b0};
    r_d = '0;
    if (ctrl_i.mod_en) begin
      // t < 3m, sign bit tells which candidate fits
      if (!t2[TW-1]) begin
        r_d = t2[WordW-1:0];
      end else if (!t1[TW-1]) begin
        r_d = t1[WordW-1:0];
      end else begin
        r_d = t[WordW-1:0];
      end
    end else begin
      r_d[PlainW-1:0] = t[PlainW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      r_q <= '0;
    end else if (ctrl_i.step) begin
      r_q <= r_d;
    end
  end

  assign prod_o = r_d;

endmodule

FILE: rtl/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Right-to-left square-and-multiply exponentiation, optionally modulo m.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : valid/ready request carrying base_value and exponent.
//   rsp_o  : valid/ready result carrying power_result.
//   cfg_*  : write port; index 0 = use_modulus, index 1 = modulus.
//            Write only while the core is idle.
// Operation:
//   One request at a time. The base is first reduced in a bit-serial pass,
//   then each exponent bit up to the highest set one costs a further pass,
//   with the square and the conditional multiply running side by side in
//   two bit-serial cells that share one scanned operand.
// Reset:
//   Back to idle, no result pending, use_modulus = 1, modulus = 2^31-1.
// Stall:
//   A finished result sits in the output register; the core takes the
//   next request meanwhile and holds its own result until the slot frees.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mxp_in_if.sink                        req_i,
  mxp_out_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [mxp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mxp_pkg::ModW-1:0]      cfg_wdata_i
);
  import mxp_pkg::*;

  // plain mode only ever shows the low 32 bits, so wrapping wider is moot
  localparam int unsigned PlainW = (DATA_WIDTH < WordW) ? DATA_WIDTH : WordW;

  mxp_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q;
  logic [WordW-1:0] base_q, acc_q, sb_q, res_q;
  logic [ExpW-1:0]  exp_q;
  logic             out_valid_q;
  logic             use_modulus_q;
  logic [ModW-1:0]  modulus_q;

  logic             mod_en, in_fire, out_fire, last_bit, load_res;
  logic [ExpW-1:0]  exp_shift;
  logic [WordW-1:0] acc_init, sq_addend, acc_prod, sq_prod;
  mxp_cell_ctrl_t   acc_ctrl, sq_ctrl;

  // zero modulus falls back to wrapping arithmetic
  assign mod_en    = use_modulus_q && (modulus_q != '0);
  assign in_fire   = req_i.valid && req_i.ready;
  assign out_fire  = out_valid_q && rsp_o.ready;
  assign last_bit  = (cnt_q == {CntW{1'b1}});
  assign exp_shift = exp_q >> 1;
  assign load_res  = (state_q == StFinish) && (!out_valid_q || rsp_o.ready);

  assign req_i.ready        = (state_q == StIdle);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.power_result = res_q;

  // acc starts at 1 mod m; with m = 1 that is 0
  assign acc_init = (mod_en && modulus_q == {{(ModW-1){1'b0}}, 1'b1}) ? '0
                                                                       : WordW'(1);

  // reduction pass: base * 1 through the square cell
  assign sq_addend = (state_q == StReduce) ? WordW'(1) : base_q;

  always_comb begin
    acc_ctrl.clr      = in_fire || ((state_q == StMult) && last_bit);
    acc_ctrl.step     = (state_q == StMult);
    acc_ctrl.scan_bit = sb_q[WordW-1];
    acc_ctrl.mod_en   = mod_en;
    sq_ctrl.clr       = in_fire ||
                        (((state_q == StMult) || (state_q == StReduce)) && last_bit);
    sq_ctrl.step      = (state_q == StMult) || (state_q == StReduce);
    sq_ctrl.scan_bit  = sb_q[WordW-1];
    sq_ctrl.mod_en    = mod_en;
  end

  mxp_mul_cell #(.PlainW(PlainW)) u_acc_cell (
    .clk_i     (clk_i),
    .ctrl_i    (acc_ctrl),
    .addend_i  (acc_q),
    .modulus_i (modulus_q),
    .prod_o    (acc_prod)
  );

  mxp_mul_cell #(.PlainW(PlainW)) u_sq_cell (
    .clk_i     (clk_i),
    .ctrl_i    (sq_ctrl),
    .addend_i  (sq_addend),
    .modulus_i (modulus_q),
    .prod_o    (sq_prod)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StReduce;
        end
      end
      StReduce: begin
        if (last_bit) begin
          state_d = (exp_q == '0) ? StFinish : StMult;
        end
      end
      StMult: begin
        if (last_bit && exp_shift == '0) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (load_res) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      use_modulus_q <= 1'b1;
      modulus_q     <= ModulusReset;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q <= '0;
      end else if ((state_q == StReduce) || (state_q == StMult)) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgUseModulus: use_modulus_q <= cfg_wdata_i[0];
          CfgModulus:    modulus_q     <= cfg_wdata_i;
          default:       ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sb_q  <= {1'b0, req_i.base_value};
      exp_q <= req_i.exponent;
      acc_q <= acc_init;
    end else if (state_q == StReduce) begin
      if (last_bit) begin
        base_q <= sq_prod;
        sb_q   <= sq_prod;
      end else begin
        sb_q <= sb_q << 1;
      end
    end else if (state_q == StMult) begin
      if (last_bit) begin
        if (exp_q[0]) begin
          acc_q <= acc_prod;
        end
        base_q <= sq_prod;
        sb_q   <= sq_prod;
        exp_q  <= exp_shift;
      end else begin
        sb_q <= sb_q << 1;
      end
    end
    if (load_res) begin
      res_q <= acc_q;
    end
  end

endmodule

FILE: rtl/mxp_checker.sv
// ----------------------------------------------------------------------------
// mxp_checker
// Port-level checks of the modular exponentiation core, bound to the top.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_assert.svh"

module mxp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [mxp_pkg::WordW-1:0] out_data_i
);

  // one request in flight: busy right after a request is taken
  `MXP_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a result never appears in the cycle after a request is taken
  `MXP_ASSERT_NEXT(a_no_instant_rsp, clk_i, rst_ni, in_valid_i && in_ready_i, !$rose(out_valid_i))

  // stalled result stays valid and unchanged
  `MXP_ASSERT_NEXT(a_rsp_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `MXP_ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))

endmodule

bind modular_exponentiation_core mxp_checker u_mxp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_data_i  (rsp_o.power_result)
);

FILE: sim/tb_modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking bench for the square-and-multiply exponentiation core.
// ----------------------------------------------------------------------------
// A table of directed requests covers reset values, field extremes, a modulus
// of one, a zero modulus and plain wrapping mode. Random phases follow, each
// under a new register setting. Expected results come from the typed powers or
// a local model, and every accepted result is compared in order. Random bursts
// and gaps on the request side and a shifting stall pattern on the result side
// vary the timing. One long result stall and several full drains add pressure.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_core;
  import mxp_pkg::*;

  localparam int unsigned DataW       = 32;
  localparam int unsigned StuckLimit  = 30000;  // cycles with no handshake at all
  localparam int unsigned LongHold    = 4000;   // long result stall, in cycles
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PhaseItems  = 34;
  localparam int unsigned DirCount    = 23;

  // one row of the directed table; power is only used when typed is set
  typedef struct packed {
    bit               use_mod;
    logic [ModW-1:0]  modulus;
    logic [ModW-1:0]  base;
    logic [ExpW-1:0]  expo;
    bit               typed;
    logic [WordW-1:0] power;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ModW-1:0]    cfg_wdata_i;

  mxp_in_if  req_if ();
  mxp_out_if rsp_if ();

  modular_exponentiation_core #(
    .DATA_WIDTH (DataW)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // local copy of the register file, updated as the bench writes it
  bit              mod_enable;
  logic [ModW-1:0] mod_value;

  logic [WordW-1:0] expected_powers[$];
  logic [WordW-1:0] oldest_power;

  dir_row_t directed_rows [DirCount];

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned requests_sent;
  int unsigned settings_used;
  int unsigned full_exponents;
  int unsigned stuck_cycles;
  int unsigned burst_left;

  // result-side stall control
  bit          hold_req;
  int unsigned hold_left;
  int unsigned mode_left;
  int unsigned ready_mode;
  logic [15:0] stall_pat;

  always #10 clk_i = ~clk_i;

  // Right-to-left square-and-multiply. Modulus mode reduces the base first,
  // every product and the final value; a zero modulus falls back to wrapping.
  function automatic logic [WordW-1:0] predict_power(input logic [ModW-1:0] b,
                                                     input logic [ExpW-1:0] e);
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned m;
    longint unsigned mask;
    logic [ExpW-1:0] rest;
    mask = (DataW >= 64) ? '1 : ((64'd1 << DataW) - 64'd1);
    rest = e;
    sq   = b;
    acc  = 1;
    if (mod_enable && mod_value != '0) begin
      m  = mod_value;
      sq = sq % m;
      while (rest != '0) begin
        if (rest[0]) acc = (acc * sq) % m;
        sq   = (sq * sq) % m;
        rest = rest >> 1;
      end
      acc = acc % m;
    end else begin
      acc = acc & mask;
      sq  = sq & mask;
      while (rest != '0) begin
        if (rest[0]) acc = (acc * sq) & mask;
        sq   = (sq * sq) & mask;
        rest = rest >> 1;
      end
    end
    return acc[WordW-1:0];
  endfunction

  // present one request and hold it until the core takes it
  task automatic offer(input logic [ModW-1:0] b, input logic [ExpW-1:0] e,
                       input bit typed, input logic [WordW-1:0] typed_power);
    req_if.valid      <= 1'b1;
    req_if.base_value <= b;
    req_if.exponent   <= e;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_powers.push_back(typed ? typed_power : predict_power(b, e));
    requests_sent++;
  endtask

  // burst bookkeeping; a gap always waits for the clock before the next offer, so
  // valid is never dropped and raised within the same step
  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: repeat ($urandom_range(1, 8)) @(posedge clk_i);
        6, 7, 8:          repeat ($urandom_range(1, 120)) @(posedge clk_i);
        default:          repeat ($urandom_range(200, 1100)) @(posedge clk_i);
      endcase
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(1, 8);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ModW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgUseModulus) mod_enable = data[0];
    else                      mod_value  = data;
  endtask

  // registers change only with the core drained; use_modulus carries junk
  // in its upper data bits, which the core must ignore
  task automatic set_config(input bit use_mod, input logic [ModW-1:0] m,
                            input bit write_all);
    logic [ModW-1:0] flag_word;
    if (write_all || use_mod != mod_enable || m != mod_value) begin
      drain_results();
      flag_word    = ModW'($urandom());
      flag_word[0] = use_mod;
      if (write_all || use_mod != mod_enable) write_reg(CfgUseModulus, flag_word);
      if (write_all || m != mod_value)        write_reg(CfgModulus, m);
      settings_used++;
    end
  endtask

  // Result side: a long hold when asked for, otherwise stretches of always
  // ready, coin flips, a rotating bit pattern, or mostly stalled.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = LongHold;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 400);
        stall_pat  = 16'($urandom());
      end
      mode_left--;
      case (ready_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= 1'($urandom_range(0, 1));
        2: begin
          rsp_if.ready <= stall_pat[0];
          stall_pat    = {stall_pat[0], stall_pat[15:1]};
        end
        default: rsp_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Result checker and watchdog. Both channels are sampled at the edge,
  // before any of this step's drives take effect.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_powers.size() == 0) begin
          $error("power_result: expected none, actual %h", rsp_if.power_result);
          mismatches++;
        end else begin
          oldest_power = expected_powers.pop_front();
          results_checked++;
          if (rsp_if.power_result !== oldest_power) begin
            $error("power_result: expected %h, actual %h",
                   oldest_power, rsp_if.power_result);
            mismatches++;
          end
        end
      end
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no request or result moved for %0d cycles", StuckLimit);
        $display("** modular_exponentiation_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [ModW-1:0] b;
    logic [ExpW-1:0] e;
    logic [ModW-1:0] m;
    bit              use_mod;

    // everything known from time zero, reset held low
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgUseModulus;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.base_value = '0;
    req_if.exponent   = '0;
    rsp_if.ready      = 1'b0;
    mod_enable        = 1'b1;
    mod_value         = ModulusReset;
    hold_req          = 1'b0;
    hold_left         = 0;
    mode_left         = 0;
    burst_left        = 1;

    // Directed table. Typed powers are the ones obvious by hand: reset,
    // exponent zero, modulus one, (m-1) powers, zero modulus, plain wraps.
    directed_rows = '{
      // reset setting: modulus 2^31-1
      '{1'b1, 31'h7FFFFFFF, 31'h0,        31'h0,        1'b1, 32'h1},
      '{1'b1, 31'h7FFFFFFF, 31'h5,        31'h0,        1'b1, 32'h1},
      '{1'b1, 31'h7FFFFFFF, 31'h0,        31'h5,        1'b1, 32'h0},
      '{1'b1, 31'h7FFFFFFF, 31'h2,        31'hA,        1'b1, 32'h400},
      '{1'b1, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1,        1'b1, 32'h0},
      '{1'b1, 31'h7FFFFFFF, 31'h7FFFFFFE, 31'h2,        1'b1, 32'h1},
      '{1'b1, 31'h7FFFFFFF, 31'h7FFFFFFE, 31'h7FFFFFFF, 1'b1, 32'h7FFFFFFE},
      '{1'b1, 31'h7FFFFFFF, 31'h3,        31'h7FFFFFFF, 1'b0, 32'h0},
      '{1'b1, 31'h7FFFFFFF, 31'h3039,     31'h2AAAAAAA, 1'b0, 32'h0},
      // modulus one: everything is zero
      '{1'b1, 31'h1,        31'h5,        31'h0,        1'b1, 32'h0},
      '{1'b1, 31'h1,        31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 32'h0},
      // small prime modulus
      '{1'b1, 31'hD,        31'h2,        31'hC,        1'b1, 32'h1},
      '{1'b1, 31'hD,        31'h64,       31'h3,        1'b0, 32'h0},
      '{1'b1, 31'hD,        31'h7FFFFFFF, 31'h55555555, 1'b0, 32'h0},
      // zero modulus behaves as plain mode
      '{1'b1, 31'h0,        31'h2,        31'h1F,       1'b1, 32'h80000000},
      '{1'b1, 31'h0,        31'h2,        31'h20,       1'b1, 32'h0},
      '{1'b1, 31'h0,        31'h3,        31'h7FFFFFFF, 1'b0, 32'h0},
      // plain mode, products wrap at 32 bits
      '{1'b0, 31'h7FFFFFFF, 31'h0,        31'h0,        1'b1, 32'h1},
      '{1'b0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h2,        1'b1, 32'h1},
      '{1'b0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, 32'h0},
      '{1'b0, 31'h7FFFFFFF, 31'h1,        31'h7FFFFFFF, 1'b1, 32'h1},
      '{1'b0, 31'h7FFFFFFF, 31'h0,        31'h7FFFFFFF, 1'b1, 32'h0},
      '{1'b0, 31'h7FFFFFFF, 31'h10000,    31'h2,        1'b1, 32'h0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      set_config(directed_rows[i].use_mod, directed_rows[i].modulus, 1'b0);
      offer(directed_rows[i].base, directed_rows[i].expo,
            directed_rows[i].typed, directed_rows[i].power);
      pace();
    end

    // Random phases, one register setting each, extremes included.
    for (int p = 0; p < PhaseCount; p++) begin
      use_mod = 1'b1;
      case (p)
        0: m = 31'h7FFFFFFF;
        1: m = ModW'($urandom()) | 31'h40000000;
        2: m = 31'h1;
        3: begin
          use_mod = 1'b0;
          m       = ModW'($urandom());
        end
        4: m = ModW'($urandom_range(2, 1000));
        5: m = '0;
        6: m = ModW'($urandom());
        default: m = 31'h2;
      endcase
      set_config(use_mod, m, 1'b1);

      for (int k = 0; k < PhaseItems; k++) begin
        // long result stall while requests keep coming: the core fills up
        // and has to push back on the request side
        if (p == 1 && k == 10) begin
          hold_req   = 1'b1;
          burst_left = 8;
        end
        // pause mid-phase until the core has handed back everything
        if (p == 4 && k == 17) drain_results();

        case ($urandom_range(0, 7))
          0:       b = '0;
          1:       b = 31'h1;
          2:       b = 31'h7FFFFFFF;
          3:       b = mod_value;          // reduces to zero in modulus mode
          4:       b = mod_value - 1'b1;   // m-1, i.e. minus one
          5:       b = ModW'($urandom_range(2, 100));
          default: b = ModW'($urandom());
        endcase
        // mostly short exponents; full-width ones take the longest
        case ($urandom_range(0, 9))
          0:       e = '0;
          1:       e = 31'h7FFFFFFF;
          2:       e = ExpW'($urandom());
          default: e = ExpW'($urandom()) & ((31'h1 << $urandom_range(1, 10)) - 1'b1);
        endcase
        if (e[30]) full_exponents++;
        offer(b, e, 1'b0, '0);
        pace();
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);

    $display("ran %0d requests (%0d directed) over %0d register settings, %0d with a top exponent bit",
             requests_sent, DirCount, settings_used, full_exponents);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_powers.size() == 0) begin
      $display("** modular_exponentiation_core: PASSED **");
    end else begin
      $display("** modular_exponentiation_core: FAILED **");
    end
    $finish;
  end

endmodule
